// File: sv/hkr_pkg.sv
// Shared types, constants and key translation functions for the HID keyboard
// report to ANSI unit. Used by the front, queue and back modules.
// No dependencies.
package hkr_pkg;

   localparam int KEY_SLOTS   = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SHIFT_BITS = 8'h22;
   localparam logic [7:0] CTRL_BITS  = 8'h11;
   localparam logic [7:0] MAP_SIZE   = 8'd57;
   localparam logic [3:0] MIN_LENGTH = 4'd2;
   localparam logic [3:0] MAX_LENGTH = 4'd9;
   localparam logic [3:0] BOOT_LENGTH = 4'd8;

   localparam logic [6:0] CH_ESC   = 7'h1B;
   localparam logic [6:0] CH_O     = 7'h4F;
   localparam logic [6:0] CH_LBR   = 7'h5B;
   localparam logic [6:0] CH_TILDE = 7'h7E;
   localparam logic [6:0] CH_LOW_A = 7'h61;
   localparam logic [6:0] CH_LOW_Z = 7'h7A;
   localparam logic [6:0] CTRL_OFS = 7'h60;

   localparam logic [7:0] KEY_F4 = 8'h3D;

   localparam logic [6:0] PLAIN_MAP [0:56] = '{
      7'h00, 7'h00, 7'h00, 7'h00, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66,
      7'h67, 7'h68, 7'h69, 7'h6A, 7'h6B, 7'h6C, 7'h6D, 7'h6E, 7'h6F, 7'h70,
      7'h71, 7'h72, 7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A,
      7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
      7'h0A, 7'h1B, 7'h08, 7'h09, 7'h20, 7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C,
      7'h00, 7'h3B, 7'h27, 7'h60, 7'h2C, 7'h2E, 7'h2F
   };

   localparam logic [6:0] SHIFT_MAP [0:56] = '{
      7'h00, 7'h00, 7'h00, 7'h00, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
      7'h47, 7'h48, 7'h49, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50,
      7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
      7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
      7'h0A, 7'h1B, 7'h08, 7'h09, 7'h20, 7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C,
      7'h00, 7'h3A, 7'h22, 7'h7E, 7'h3C, 7'h3E, 7'h3F
   };

   typedef logic [KEY_SLOTS-1:0][7:0] slot_keys_type;

   typedef struct packed {
      logic [7:0] key;
      logic       shift;
      logic       ctrl;
      logic       last;
   } key_entry_type;

   function automatic logic [2:0] seq_len(input logic [7:0] key);
      logic [2:0] n;
      unique case (key)
         8'h3A, 8'h3B, 8'h3C, 8'h3D:                             n = 3'd3;
         8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45: n = 3'd5;
         8'h49, 8'h4B, 8'h4C, 8'h4E:                             n = 3'd4;
         8'h4A, 8'h4D, 8'h4F, 8'h50, 8'h51, 8'h52:               n = 3'd3;
         default:                                                n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [6:0] seq_third(input logic [7:0] key);
      logic [6:0] c;
      unique case (key)
         8'h3A:                      c = 7'h50;
         8'h3B:                      c = 7'h51;
         8'h3C:                      c = 7'h52;
         8'h3D:                      c = 7'h53;
         8'h3E, 8'h3F, 8'h40, 8'h41: c = 7'h31;
         8'h42, 8'h43, 8'h44, 8'h45: c = 7'h32;
         8'h49:                      c = 7'h32;
         8'h4A:                      c = 7'h48;
         8'h4B:                      c = 7'h35;
         8'h4C:                      c = 7'h33;
         8'h4D:                      c = 7'h46;
         8'h4E:                      c = 7'h36;
         8'h4F:                      c = 7'h43;
         8'h50:                      c = 7'h44;
         8'h51:                      c = 7'h42;
         8'h52:                      c = 7'h41;
         default:                    c = 7'h00;
      endcase
      return c;
   endfunction

   function automatic logic [6:0] seq_fourth(input logic [7:0] key);
      logic [6:0] c;
      unique case (key)
         8'h3E:                      c = 7'h35;
         8'h3F:                      c = 7'h37;
         8'h40:                      c = 7'h38;
         8'h41:                      c = 7'h39;
         8'h42:                      c = 7'h30;
         8'h43:                      c = 7'h31;
         8'h44:                      c = 7'h33;
         8'h45:                      c = 7'h34;
         8'h49, 8'h4B, 8'h4C, 8'h4E: c = CH_TILDE;
         default:                    c = 7'h00;
      endcase
      return c;
   endfunction

   function automatic logic [6:0] seq_char(input logic [7:0] key, input logic [2:0] idx);
      logic [6:0] c;
      unique case (idx)
         3'd0:    c = CH_ESC;
         3'd1:    c = (key <= KEY_F4) ? CH_O : CH_LBR;
         3'd2:    c = seq_third(key);
         3'd3:    c = seq_fourth(key);
         default: c = CH_TILDE;
      endcase
      return c;
   endfunction

   function automatic logic [6:0] map_char(input logic [7:0] key, input logic shift,
                                           input logic ctrl);
      logic [6:0] c;
      c = 7'h00;
      if (key < MAP_SIZE) begin
         c = shift ? SHIFT_MAP[key[5:0]] : PLAIN_MAP[key[5:0]];
         if (ctrl && c >= CH_LOW_A && c <= CH_LOW_Z) begin
            c = c - CTRL_OFS;
         end
      end
      return c;
   endfunction

   function automatic logic [2:0] char_count(input logic [7:0] key, input logic shift,
                                             input logic ctrl);
      logic [2:0] n;
      n = seq_len(key);
      if (n == 3'd0) begin
         n = (map_char(key, shift, ctrl) != 7'h00) ? 3'd1 : 3'd0;
      end
      return n;
   endfunction

endpackage

// File: sv/hid_keyboard_report_to_ansi_unit.sv
// Top level of the HID keyboard report to ANSI character unit.
// Depends on hkr_pkg, hkr_front, hkr_queue and hkr_back.
//
// Usage:
//   req_*  carries one keyboard report per transfer: length, modifier byte and
//          bytes 1 to 7. A report is taken whenever req_stall is low.
//   rsp_*  carries one 7-bit character per transfer; rsp_last_of_report marks
//          the final character of a report. A report that yields nothing
//          gives no transfer at all.
// Timing:
//   The intake scans the six key slots one per cycle, holding a new key while
//   the 4-entry key queue is full, as long escape sequences can make it; so
//   req_stall stays high after a report with new presses until its last new
//   key is queued, and not at all after a report without any. The first
//   character passes the stored slots, the key queue and the sequencer to the
//   output register, waiting a shift for each slot ahead of the first new key.
//   The sequencer sends one character per cycle while rsp_stall is low and
//   loads each key from the queue first; a report yields up to 30 characters.
// Stalls and reset:
//   rsp_stall holds the output register; the key queue then fills and the
//   intake stalls in turn. Reset clears the stored key slots to zero, empties
//   the queue and drops rsp_valid.
module hid_keyboard_report_to_ansi_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [3:0] req_report_length,
   input  logic [7:0] req_modifier_byte,
   input  logic [7:0] req_report_byte1,
   input  logic [7:0] req_report_byte2,
   input  logic [7:0] req_report_byte3,
   input  logic [7:0] req_report_byte4,
   input  logic [7:0] req_report_byte5,
   input  logic [7:0] req_report_byte6,
   input  logic [7:0] req_report_byte7,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last_of_report
);

   logic                   push_valid;
   hkr_pkg::key_entry_type push_data;
   logic                   queue_full;
   logic                   queue_empty;
   logic                   queue_pop;
   hkr_pkg::key_entry_type queue_head;

   hkr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_report_length (req_report_length),
      .req_modifier_byte (req_modifier_byte),
      .req_report_byte1  (req_report_byte1),
      .req_report_byte2  (req_report_byte2),
      .req_report_byte3  (req_report_byte3),
      .req_report_byte4  (req_report_byte4),
      .req_report_byte5  (req_report_byte5),
      .req_report_byte6  (req_report_byte6),
      .req_report_byte7  (req_report_byte7),
      .push_valid        (push_valid),
      .push_data         (push_data),
      .queue_full        (queue_full)
   );

   hkr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .head      (queue_head),
      .empty     (queue_empty)
   );

   hkr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (queue_head),
      .empty              (queue_empty),
      .pop                (queue_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_of_report (rsp_last_of_report)
   );

endmodule

// File: sv/hkr_front.sv
// Report intake: finds new key presses against the stored slots, updates the
// stored slots and feeds one queue entry per key that produces characters.
// Depends on hkr_pkg.
module hkr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [3:0]             req_report_length,
   input  logic [7:0]             req_modifier_byte,
   input  logic [7:0]             req_report_byte1,
   input  logic [7:0]             req_report_byte2,
   input  logic [7:0]             req_report_byte3,
   input  logic [7:0]             req_report_byte4,
   input  logic [7:0]             req_report_byte5,
   input  logic [7:0]             req_report_byte6,
   input  logic [7:0]             req_report_byte7,
   output logic                   push_valid,
   output hkr_pkg::key_entry_type push_data,
   input  logic                   queue_full
);

   logic [hkr_pkg::KEY_SLOTS-1:0] pend_ff, pend_in, pend_new;
   hkr_pkg::slot_keys_type        key_ff, key_in, key_new;
   hkr_pkg::slot_keys_type        prev_ff, prev_in, prev_new;
   logic                          shift_ff, ctrl_ff, shift_new, ctrl_new;
   logic [7:0]                    bytes [8];
   logic [3:0]                    len_c;
   logic [3:0]                    start;
   logic [3:0]                    pos;
   logic                          slot_ok;
   logic                          seen;
   logic                          busy;
   logic                          take;
   logic                          advance;

   assign busy      = |pend_ff;
   assign req_stall = busy;
   assign take      = req_valid && !busy && (req_report_length >= hkr_pkg::MIN_LENGTH);

   assign push_valid     = pend_ff[0];
   assign push_data.key   = key_ff[0];
   assign push_data.shift = shift_ff;
   assign push_data.ctrl  = ctrl_ff;
   assign push_data.last  = ((pend_ff >> 1) == '0);
   assign advance        = busy && (!pend_ff[0] || !queue_full);

   always_comb begin
      bytes[0] = req_modifier_byte;
      bytes[1] = req_report_byte1;
      bytes[2] = req_report_byte2;
      bytes[3] = req_report_byte3;
      bytes[4] = req_report_byte4;
      bytes[5] = req_report_byte5;
      bytes[6] = req_report_byte6;
      bytes[7] = req_report_byte7;
      len_c = (req_report_length > hkr_pkg::MAX_LENGTH) ? hkr_pkg::MAX_LENGTH
                                                        : req_report_length;
      start = (len_c == hkr_pkg::BOOT_LENGTH) ? 4'd2 : 4'd1;
      shift_new = (req_modifier_byte & hkr_pkg::SHIFT_BITS) != 8'h00;
      ctrl_new  = (req_modifier_byte & hkr_pkg::CTRL_BITS) != 8'h00;
      pend_new = '0;
      key_new  = '0;
      prev_new = '0;
      for (int i = 0; i < hkr_pkg::KEY_SLOTS; i++) begin
         pos = start + 4'(i);
         slot_ok = pos < len_c;
         key_new[i] = bytes[pos[2:0]];
         seen = 1'b0;
         for (int j = 0; j < hkr_pkg::KEY_SLOTS; j++) begin
            if (prev_ff[j] == key_new[i]) begin
               seen = 1'b1;
            end
         end
         prev_new[i] = slot_ok ? key_new[i] : 8'h00;
         pend_new[i] = slot_ok && (key_new[i] != 8'h00) && !seen &&
                       (hkr_pkg::char_count(key_new[i], shift_new, ctrl_new) != 3'd0);
      end
   end

   always_comb begin
      pend_in = pend_ff;
      key_in  = key_ff;
      prev_in = prev_ff;
      if (take) begin
         pend_in = pend_new;
         key_in  = key_new;
         prev_in = prev_new;
      end else if (advance) begin
         pend_in = pend_ff >> 1;
         for (int i = 0; i < hkr_pkg::KEY_SLOTS - 1; i++) begin
            key_in[i] = key_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         prev_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (take) begin
         shift_ff <= shift_new;
         ctrl_ff  <= ctrl_new;
      end
   end

endmodule

// File: sv/hkr_queue.sv
// Short FIFO of pressed-key entries between the report intake and the
// character sequencer. Depends on hkr_pkg.
module hkr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hkr_pkg::key_entry_type push_data,
   output logic                   full,
   input  logic                   pop,
   output hkr_pkg::key_entry_type head,
   output logic                   empty
);

   hkr_pkg::key_entry_type            mem_ff [hkr_pkg::QUEUE_DEPTH];
   logic [hkr_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [hkr_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [hkr_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              do_push, do_pop;

   assign full    = count_ff == hkr_pkg::QCNT_W'(hkr_pkg::QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == hkr_pkg::QPTR_W'(hkr_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + hkr_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == hkr_pkg::QPTR_W'(hkr_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + hkr_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + hkr_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - hkr_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/hkr_back.sv
// Character sequencer: expands one queued key into its escape sequence or
// mapped character and drives the registered result channel. Depends on hkr_pkg.
module hkr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  hkr_pkg::key_entry_type head,
   input  logic                   empty,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [6:0]             rsp_out_char,
   output logic                   rsp_last_of_report
);

   logic                   active_ff, active_in;
   logic [2:0]             idx_ff, idx_in;
   logic [2:0]             len_ff;
   hkr_pkg::key_entry_type cur_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [6:0]             rsp_char_ff;
   logic                   rsp_last_ff;
   logic                   out_free;
   logic                   emit;
   logic                   final_char;
   logic [6:0]             next_char;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign pop        = !active_ff && !empty;
   assign emit       = active_ff && out_free;
   assign final_char = idx_ff == (len_ff - 3'd1);
   assign next_char  = (hkr_pkg::seq_len(cur_ff.key) != 3'd0)
                       ? hkr_pkg::seq_char(cur_ff.key, idx_ff)
                       : hkr_pkg::map_char(cur_ff.key, cur_ff.shift, cur_ff.ctrl);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_char       = rsp_char_ff;
   assign rsp_last_of_report = rsp_last_ff;

   always_comb begin
      active_in    = active_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         active_in = 1'b1;
         idx_in    = 3'd0;
      end else if (emit) begin
         idx_in = idx_ff + 3'd1;
         if (final_char) begin
            active_in = 1'b0;
         end
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
         len_ff <= hkr_pkg::char_count(head.key, head.shift, head.ctrl);
      end
      if (emit) begin
         rsp_char_ff <= next_char;
         rsp_last_ff <= cur_ff.last && final_char;
      end
   end

endmodule

// File: sv/hkr_checker.sv
// Port-level checks for the HID keyboard report to ANSI unit, bound to the
// top level. Depends on hid_keyboard_report_to_ansi_unit.
module hkr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [3:0] req_report_length,
   input logic [7:0] req_modifier_byte,
   input logic [7:0] req_report_byte1,
   input logic [7:0] req_report_byte2,
   input logic [7:0] req_report_byte3,
   input logic [7:0] req_report_byte4,
   input logic [7:0] req_report_byte5,
   input logic [7:0] req_report_byte6,
   input logic [7:0] req_report_byte7,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [6:0] rsp_out_char,
   input logic       rsp_last_of_report
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) &&
                                 $stable(rsp_last_of_report))
      else $error("stalled result changed");

   a_no_null_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_char != 7'h00)
      else $error("null character sent");

   a_reset_rsp_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_req_open: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("intake stalled right after reset");

endmodule

bind hid_keyboard_report_to_ansi_unit hkr_checker u_checker (.*);
